// ----- hw/rtl/kac_pkg.sv -----
// Shared types, constants and name ROM of the key-exchange-init algorithm checker.
`timescale 1ns / 1ps

package kac_pkg;

	localparam logic [7:0] MSG_TYPE_KEXINIT = 8'd20;
	localparam int         COOKIE_BYTES     = 16;
	localparam int         LEN_BYTES        = 4;
	localparam logic [7:0] COMMA            = 8'h2c;
	localparam int         POS_W            = 5;

	localparam int KEX_LEN  = 17;
	localparam int HOST_LEN = 11;
	localparam int CIPH_LEN = 7;

	localparam logic [8*KEX_LEN-1:0]  NAME_KEX  = "curve25519-sha256";
	localparam logic [8*HOST_LEN-1:0] NAME_HOST = "ssh-ed25519";
	localparam logic [8*CIPH_LEN-1:0] NAME_CIPH = "[email]";

	typedef enum logic [5:0] {
		PH_TYPE   = 6'b000001,
		PH_COOKIE = 6'b000010,
		PH_LEN    = 6'b000100,
		PH_BODY   = 6'b001000,
		PH_TRAIL  = 6'b010000,
		PH_SKIP   = 6'b100000
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_TYPE  = 2'd2,
		ST_TRUNC = 2'd3
	} status_t;

	// Commands from the parser to the entry matcher for one beat.
	typedef struct packed {
		logic       step;
		logic       close;
		logic       restart;
		logic       clear;
		logic       checked;
		logic [1:0] sel;
		logic [7:0] data;
	} tok_cmd_t;

	typedef struct packed {
		logic       accepted;
		status_t    status;
		logic [3:0] found;
	} result_t;

	function automatic logic [POS_W-1:0] name_len(input logic [1:0] sel);
		logic [POS_W-1:0] len;
		case (sel)
			2'd0:    len = POS_W'(KEX_LEN);
			2'd1:    len = POS_W'(HOST_LEN);
			default: len = POS_W'(CIPH_LEN);
		endcase
		return len;
	endfunction

	function automatic logic [7:0] name_char(input logic [1:0] sel,
	                                         input logic [POS_W-1:0] pos);
		logic [8*KEX_LEN-1:0]  kex;
		logic [8*HOST_LEN-1:0] host;
		logic [8*CIPH_LEN-1:0] ciph;
		logic [7:0]            ch;
		kex  = NAME_KEX;
		host = NAME_HOST;
		ciph = NAME_CIPH;
		ch   = 8'h00;
		case (sel)
			2'd0: begin
				if (pos < POS_W'(KEX_LEN))
					ch = kex[8*(KEX_LEN-1-int'(pos)) +: 8];
			end
			2'd1: begin
				if (pos < POS_W'(HOST_LEN))
					ch = host[8*(HOST_LEN-1-int'(pos)) +: 8];
			end
			default: begin
				if (pos < POS_W'(CIPH_LEN))
					ch = ciph[8*(CIPH_LEN-1-int'(pos)) +: 8];
			end
		endcase
		return ch;
	endfunction

endpackage

// ----- hw/rtl/kac_in_if.sv -----
// Input channel: one message byte per beat with a final-byte flag.
`timescale 1ns / 1ps

interface kac_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] msg_byte;
	logic       msg_last;

	modport source (output valid, output msg_byte, output msg_last, input ready);
	modport sink   (input valid, input msg_byte, input msg_last, output ready);
endinterface

// ----- hw/rtl/kac_out_if.sv -----
// Result channel: verdict, status and found flags for one message.
`timescale 1ns / 1ps

interface kac_out_if;
	logic       valid;
	logic       ready;
	logic       accepted;
	logic [1:0] status;
	logic       kex_found;
	logic       hostkey_found;
	logic       cipher_cs_found;
	logic       cipher_sc_found;

	modport source (output valid, output accepted, output status, output kex_found,
	                output hostkey_found, output cipher_cs_found, output cipher_sc_found,
	                input ready);
	modport sink   (input valid, input accepted, input status, input kex_found,
	                input hostkey_found, input cipher_cs_found, input cipher_sc_found,
	                output ready);
endinterface

// ----- hw/rtl/kexinit_algorithm_checker.sv -----
// Top level of the key-exchange-init algorithm checker.
`timescale 1ns / 1ps

// Takes one message byte per cycle and gives one result per message, held in
// the output register once its final byte has passed the input register. A
// byte passes an input register, then the framing state and entry matcher
// update in that cycle, and the result lands in an output register. No beat
// waits but a final byte, and that only while the previous result still sits
// unread in the output register. After a result the parser is back at the type
// byte with nothing else to do, so the next message can follow at once.
module kexinit_algorithm_checker #(
	parameter int LIST_COUNT    = 10,
	parameter int CHECKED_LISTS = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	kac_in_if.sink   msg,
	kac_out_if.source res
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              advance;
	logic              out_valid_q;
	kac_pkg::result_t  out_q;
	kac_pkg::result_t  par_res;
	logic              par_fire;
	kac_pkg::tok_cmd_t tok;
	logic [CHECKED_LISTS-1:0] found_next;

	// hold a final byte while the previous result is still pending
	assign advance   = valid_s1 && (!last_s1 || !out_valid_q || res.ready);
	assign msg.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.valid && msg.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready) begin
			byte_s1 <= msg.msg_byte;
			last_s1 <= msg.msg_last;
		end
	end

	kac_parser #(
		.LIST_COUNT    (LIST_COUNT),
		.CHECKED_LISTS (CHECKED_LISTS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.data       (byte_s1),
		.last       (last_s1),
		.found_next (found_next),
		.tok        (tok),
		.res        (par_res),
		.res_fire   (par_fire)
	);

	kac_token #(
		.CHECKED_LISTS (CHECKED_LISTS)
	) u_token (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (tok),
		.found_next (found_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (par_fire) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (par_fire)
			out_q <= par_res;
	end

	assign res.valid           = out_valid_q;
	assign res.accepted        = out_q.accepted;
	assign res.status          = out_q.status;
	assign res.kex_found       = out_q.found[0];
	assign res.hostkey_found   = out_q.found[1];
	assign res.cipher_cs_found = out_q.found[2];
	assign res.cipher_sc_found = out_q.found[3];

endmodule

// ----- hw/rtl/kac_token.sv -----
// Entry matcher: compares comma-separated entries against the required names.
`timescale 1ns / 1ps

module kac_token #(
	parameter int CHECKED_LISTS = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  kac_pkg::tok_cmd_t        cmd,
	output logic [CHECKED_LISTS-1:0] found_next
);

	logic [kac_pkg::POS_W-1:0] pos_q, pos_a;
	logic                      match_q, match_a;
	logic [CHECKED_LISTS-1:0]  found_q;
	logic [kac_pkg::POS_W-1:0] len;
	logic                      hit;

	always_comb begin
		len   = kac_pkg::name_len(cmd.sel);
		pos_a = pos_q;
		match_a = match_q;
		hit   = 1'b0;
		if (cmd.restart) begin
			pos_a   = '0;
			match_a = 1'b1;
		end
		if (cmd.step && cmd.checked) begin
			if (cmd.data == kac_pkg::COMMA) begin
				hit     = match_a && (pos_a == len);
				pos_a   = '0;
				match_a = 1'b1;
			end else if (match_a && (pos_a < len) &&
			             (cmd.data == kac_pkg::name_char(cmd.sel, pos_a))) begin
				pos_a = pos_a + 1'b1;
			end else begin
				match_a = 1'b0;
			end
		end
		// list end closes the open entry
		if (cmd.close && cmd.checked) begin
			hit     = hit || (match_a && (pos_a == len));
			pos_a   = '0;
			match_a = 1'b1;
		end
		found_next = found_q;
		for (int i = 0; i < CHECKED_LISTS; i++) begin
			if (hit && (cmd.sel == 2'(i)))
				found_next[i] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			match_q <= 1'b1;
			found_q <= '0;
		end else if (cmd.clear) begin
			pos_q   <= '0;
			match_q <= 1'b1;
			found_q <= '0;
		end else begin
			pos_q   <= pos_a;
			match_q <= match_a;
			found_q <= found_next;
		end
	end

endmodule

// ----- hw/rtl/kac_parser.sv -----
// Message framing: type byte, cookie, length prefixes and list bodies.
`timescale 1ns / 1ps

module kac_parser #(
	parameter int LIST_COUNT    = 10,
	parameter int CHECKED_LISTS = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic [7:0]               data,
	input  logic                     last,
	input  logic [CHECKED_LISTS-1:0] found_next,
	output kac_pkg::tok_cmd_t        tok,
	output kac_pkg::result_t         res,
	output logic                     res_fire
);

	localparam int LIW = $clog2(LIST_COUNT);

	kac_pkg::phase_t   phase_q, phase_n;
	logic [4:0]        count_q, count_n, count_inc;
	logic [LIW-1:0]    list_q, list_n;
	logic [31:0]       accum_q, accum_n;
	logic [31:0]       remain_q, remain_n;
	logic              err_q, err_n;
	kac_pkg::tok_cmd_t cmd;
	kac_pkg::status_t  status;
	logic [3:0]        found4;
	logic              list_last;

	always_comb begin
		phase_n   = phase_q;
		count_n   = count_q;
		list_n    = list_q;
		accum_n   = accum_q;
		remain_n  = remain_q;
		err_n     = err_q;
		count_inc = count_q + 1'b1;
		list_last = (list_q == LIW'(LIST_COUNT - 1));
		cmd         = '0;
		cmd.data    = data;
		cmd.sel     = list_q[1:0];
		cmd.checked = (int'(list_q) < CHECKED_LISTS);

		case (phase_q)
			kac_pkg::PH_TYPE: begin
				err_n   = (data != kac_pkg::MSG_TYPE_KEXINIT);
				phase_n = kac_pkg::PH_COOKIE;
				count_n = '0;
			end
			kac_pkg::PH_COOKIE: begin
				count_n = count_inc;
				if (int'(count_inc) >= kac_pkg::COOKIE_BYTES) begin
					phase_n = err_q ? kac_pkg::PH_SKIP : kac_pkg::PH_LEN;
					count_n = '0;
					accum_n = '0;
				end
			end
			kac_pkg::PH_LEN: begin
				accum_n = {accum_q[23:0], data};
				count_n = count_inc;
				if (int'(count_inc) >= kac_pkg::LEN_BYTES) begin
					remain_n    = accum_n;
					cmd.restart = 1'b1;
					if (accum_n == '0) begin
						cmd.close = 1'b1;
						if (list_last) begin
							phase_n = kac_pkg::PH_TRAIL;
						end else begin
							list_n  = list_q + 1'b1;
							phase_n = kac_pkg::PH_LEN;
							count_n = '0;
							accum_n = '0;
						end
					end else begin
						phase_n = kac_pkg::PH_BODY;
					end
				end
			end
			kac_pkg::PH_BODY: begin
				cmd.step = 1'b1;
				remain_n = remain_q - 1'b1;
				if (remain_q == 32'd1) begin
					cmd.close = 1'b1;
					if (list_last) begin
						phase_n = kac_pkg::PH_TRAIL;
					end else begin
						list_n  = list_q + 1'b1;
						phase_n = kac_pkg::PH_LEN;
						count_n = '0;
						accum_n = '0;
					end
				end
			end
			default: begin
			end
		endcase

		tok = cmd;
		if (!en) begin
			tok.step    = 1'b0;
			tok.close   = 1'b0;
			tok.restart = 1'b0;
		end
		tok.clear = en && last;
	end

	always_comb begin
		case (phase_n)
			kac_pkg::PH_COOKIE: status = kac_pkg::ST_SHORT;
			kac_pkg::PH_SKIP:   status = kac_pkg::ST_TYPE;
			kac_pkg::PH_LEN,
			kac_pkg::PH_BODY:   status = kac_pkg::ST_TRUNC;
			default:            status = kac_pkg::ST_OK;
		endcase

		found4 = '0;
		found4[CHECKED_LISTS-1:0] = found_next;
		res.status   = status;
		res.found    = (status == kac_pkg::ST_OK) ? found4 : 4'b0000;
		res.accepted = (status == kac_pkg::ST_OK) && (&found_next);
		res_fire     = en && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= kac_pkg::PH_TYPE;
			count_q  <= '0;
			list_q   <= '0;
			accum_q  <= '0;
			remain_q <= '0;
			err_q    <= 1'b0;
		end else if (en && last) begin
			// restart for the next message
			phase_q  <= kac_pkg::PH_TYPE;
			count_q  <= '0;
			list_q   <= '0;
			accum_q  <= '0;
			remain_q <= '0;
			err_q    <= 1'b0;
		end else if (en) begin
			phase_q  <= phase_n;
			count_q  <= count_n;
			list_q   <= list_n;
			accum_q  <= accum_n;
			remain_q <= remain_n;
			err_q    <= err_n;
		end
	end

endmodule
